@@ hw/rtl/sigdot_pkg.sv @@
// Shared types, constants, sigmoid table and saturation helper for the sigmoid neuron unit.
package sigdot_pkg;

   localparam int MAX_INPUTS_DEF = 64;
   localparam int SIG_ENTRIES    = 256;
   localparam int SIG_LOG2       = $clog2(SIG_ENTRIES);
   localparam int IDX_W          = SIG_LOG2 + 1;

   localparam int INDEX_W = 6;
   localparam int VALUE_W = 16;
   localparam int COUNT_W = 7;
   localparam int ACT_W   = 16;
   localparam int FRAC_W  = 16;
   localparam int ACC_W   = 40;
   localparam int Z_W     = 57;
   localparam int U_W     = 37;
   localparam int CSR_W   = 2;

   localparam logic [CSR_W-1:0] CSR_INPUT_COUNT = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BIAS_WEIGHT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_BIAS_INPUT  = 2'd2;
   localparam logic [CSR_W-1:0] CSR_INV_RESP    = 2'd3;

   localparam logic [COUNT_W-1:0]        INPUT_COUNT_RST = 7'd1;
   localparam logic signed [VALUE_W-1:0] BIAS_WEIGHT_RST = 16'sd0;
   localparam logic signed [VALUE_W-1:0] BIAS_INPUT_RST  = 16'sd4096;
   localparam logic [VALUE_W-1:0]        INV_RESP_RST    = 16'd256;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef logic [SIG_ENTRIES:0][ACT_W-1:0] sig_table_type;

   typedef struct packed {
      logic                    valid;
      logic signed [ACC_W-1:0] sum;
      logic                    count_error;
   } sigdot_sum_type;

   typedef struct packed {
      logic             valid;
      logic [ACT_W-1:0] activation;
      logic             count_error;
   } sigdot_result_type;

   typedef struct packed {
      logic [ACT_W-1:0] activation;
      logic             count_error;
   } sigdot_rsp_type;

   function automatic logic signed [ACC_W-1:0] sat40(input logic signed [ACC_W:0] v);
      logic signed [ACC_W-1:0] r;
      if (v[ACC_W] != v[ACC_W-1]) begin
         r = v[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   // restoring shift-subtract quotient, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tab;
      longint        x;
      logic [63:0]   t;
      logic [63:0]   y;
      logic [63:0]   y2;
      logic [63:0]   y3;
      logic [63:0]   y4;
      logic [63:0]   e;
      logic [63:0]   den;
      logic [63:0]   num;
      logic [63:0]   s;
      logic [63:0]   q_one;
      tab   = '0;
      q_one = 64'd1 << 31;
      for (int k = 0; k <= SIG_ENTRIES; k++) begin
         x  = ((longint'(k) * 64'sd16 * 64'sd65536) >>> SIG_LOG2) - 64'sd524288;
         t  = (x < 0) ? 64'(-x) : 64'(x);
         y  = t << 7;
         y2 = (y * y) >> 31;
         y3 = (y2 * y) >> 31;
         y4 = (y3 * y) >> 31;
         e  = q_one - y + (y2 >> 1) - udiv64(y3, 64'd6) + udiv64(y4, 64'd24);
         for (int n = 0; n < 8; n++) begin
            e = (e * e + (q_one >> 1)) >> 31;
         end
         den = q_one + e;
         num = (x >= 0) ? (64'd1 << 47) : (e << 16);
         s   = udiv64(num + (den >> 1), den);
         if (s > 64'd65535) begin
            s = 64'd65535;
         end
         tab[k] = s[ACT_W-1:0];
      end
      return tab;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

@@ hw/rtl/sigdot_mac.sv @@
// Weight memory, sample multiply and saturating accumulate with sample count.
module sigdot_mac #(
   parameter int MAX_INPUTS = sigdot_pkg::MAX_INPUTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_take,
   input  logic                                  item_mode,
   input  logic [sigdot_pkg::INDEX_W-1:0]        item_index,
   input  logic signed [sigdot_pkg::VALUE_W-1:0] item_value,
   input  logic                                  item_last,
   input  logic [sigdot_pkg::COUNT_W-1:0]        input_count,
   output sigdot_pkg::sigdot_sum_type            sum_out
);

   localparam int ADDR_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam logic [sigdot_pkg::COUNT_W-1:0] COUNT_MAX = '1;

   logic [sigdot_pkg::VALUE_W-1:0] weight_mem [MAX_INPUTS];

   logic [ADDR_W-1:0] addr;
   logic              in_range;

   logic                                  a_valid_ff;
   logic                                  a_last_ff;
   logic                                  a_zero_ff;
   logic signed [sigdot_pkg::VALUE_W-1:0] a_value_ff;
   logic [sigdot_pkg::VALUE_W-1:0]        rd_data_ff;

   logic signed [sigdot_pkg::VALUE_W-1:0]   weight;
   logic signed [2*sigdot_pkg::VALUE_W-1:0] prod_in;
   logic signed [2*sigdot_pkg::VALUE_W-1:0] prod_ff;
   logic                                    b_valid_ff;
   logic                                    b_last_ff;

   logic signed [sigdot_pkg::ACC_W-1:0] acc_ff;
   logic signed [sigdot_pkg::ACC_W-1:0] acc_sat;
   logic [sigdot_pkg::COUNT_W-1:0]      cnt_ff;
   logic [sigdot_pkg::COUNT_W-1:0]      cnt_next;
   sigdot_pkg::sigdot_sum_type          sum_ff;

   assign addr     = ADDR_W'(item_index);
   assign in_range = 32'(item_index) < 32'(MAX_INPUTS);

   always_ff @(posedge clock) begin
      if (item_take && !item_mode && in_range) begin
         weight_mem[addr] <= item_value;
      end
      if (item_take && item_mode) begin
         rd_data_ff <= weight_mem[addr];
         a_value_ff <= item_value;
         a_last_ff  <= item_last;
         a_zero_ff  <= !in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= item_take && item_mode;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_comb begin
      weight  = a_zero_ff ? '0 : $signed(rd_data_ff);
      prod_in = (2*sigdot_pkg::VALUE_W)'(a_value_ff) * (2*sigdot_pkg::VALUE_W)'(weight);
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         prod_ff   <= prod_in;
         b_last_ff <= a_last_ff;
      end
   end

   always_comb begin
      acc_sat  = sigdot_pkg::sat40((sigdot_pkg::ACC_W+1)'(acc_ff)
                                   + (sigdot_pkg::ACC_W+1)'(prod_ff));
      cnt_next = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 7'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         sum_ff.valid <= 1'b0;
      end else begin
         sum_ff.valid <= b_valid_ff && b_last_ff;
         if (b_valid_ff) begin
            if (b_last_ff) begin
               acc_ff             <= '0;
               cnt_ff             <= '0;
               sum_ff.sum         <= acc_sat;
               sum_ff.count_error <= cnt_next != input_count;
            end else begin
               acc_ff <= acc_sat;
               cnt_ff <= cnt_next;
            end
         end
      end
   end

   assign sum_out = sum_ff;

endmodule

@@ hw/rtl/sigdot_act.sv @@
// Bias add, response scaling, clamp and interpolated sigmoid lookup.
module sigdot_act (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sigdot_pkg::sigdot_sum_type              sum_in,
   input  logic signed [2*sigdot_pkg::VALUE_W-1:0] bias_product,
   input  logic [sigdot_pkg::VALUE_W-1:0]          inv_resp,
   output sigdot_pkg::sigdot_result_type           result
);

   localparam logic signed [sigdot_pkg::Z_W-1:0] Z_LIM = 57'sd34359738368;
   localparam logic [sigdot_pkg::U_W-1:0]        U_TOP = 37'h10_0000_0000;
   localparam int FRAC_MSB = 35 - sigdot_pkg::SIG_LOG2;

   logic [3:0] valid_ff;
   logic [3:0] err_ff;

   logic signed [sigdot_pkg::ACC_W-1:0] s_in;
   logic signed [sigdot_pkg::ACC_W-1:0] s_ff;

   logic [39:0]        lo_in;
   logic [39:0]        lo_ff;
   logic signed [32:0] hi_in;
   logic signed [32:0] hi_ff;

   logic signed [sigdot_pkg::Z_W-1:0]  z;
   logic [sigdot_pkg::U_W-1:0]         u;
   logic [sigdot_pkg::IDX_W-1:0]       idx_ff;
   logic [sigdot_pkg::FRAC_W-1:0]      frac_ff;

   logic [sigdot_pkg::IDX_W-1:0]       next_idx;
   logic [sigdot_pkg::ACT_W-1:0]       base_in;
   logic [sigdot_pkg::ACT_W-1:0]       next_val;
   logic [sigdot_pkg::ACT_W-1:0]       base_ff;
   logic signed [sigdot_pkg::ACT_W:0]  diff_in;
   logic signed [sigdot_pkg::ACT_W:0]  diff_ff;
   logic [sigdot_pkg::FRAC_W-1:0]      frac_g_ff;

   logic signed [34:0]                 r;
   logic [sigdot_pkg::ACT_W-1:0]       act_in;
   sigdot_pkg::sigdot_result_type      result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= '0;
         result_ff.valid <= 1'b0;
      end else begin
         valid_ff        <= {valid_ff[2:0], sum_in.valid};
         result_ff.valid <= valid_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= {err_ff[2:0], sum_in.count_error};
   end

   always_comb begin
      s_in  = sigdot_pkg::sat40((sigdot_pkg::ACC_W+1)'(sum_in.sum)
                                + (sigdot_pkg::ACC_W+1)'(bias_product));
      lo_in = 40'(s_ff[23:0]) * 40'(inv_resp);
      hi_in = 33'($signed(s_ff[39:24])) * 33'($signed({1'b0, inv_resp}));
   end

   always_comb begin
      z = (sigdot_pkg::Z_W'(hi_ff) <<< 24) + $signed({17'b0, lo_ff});
      priority if (z < -Z_LIM) begin
         u = '0;
      end else if (z > Z_LIM) begin
         u = U_TOP;
      end else begin
         u = sigdot_pkg::U_W'(z + Z_LIM);
      end
   end

   always_comb begin
      next_idx = idx_ff[sigdot_pkg::SIG_LOG2] ? idx_ff
                                              : idx_ff + sigdot_pkg::IDX_W'(1);
      base_in  = sigdot_pkg::SIG_TABLE[idx_ff];
      next_val = sigdot_pkg::SIG_TABLE[next_idx];
      diff_in  = $signed({1'b0, next_val}) - $signed({1'b0, base_in});
   end

   always_comb begin
      r = $signed({3'b0, base_ff, 16'b0})
          + 35'(diff_ff) * 35'($signed({1'b0, frac_g_ff}))
          + 35'sd32768;
      priority if (r[34]) begin
         act_in = '0;
      end else if (|r[33:32]) begin
         act_in = '1;
      end else begin
         act_in = r[31:16];
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= u[sigdot_pkg::U_W-1 -: sigdot_pkg::IDX_W];
      frac_ff   <= u[FRAC_MSB -: sigdot_pkg::FRAC_W];
      base_ff   <= base_in;
      diff_ff   <= diff_in;
      frac_g_ff <= frac_ff;
      result_ff.activation  <= act_in;
      result_ff.count_error <= err_ff[3];
   end

   assign result = result_ff;

endmodule

@@ hw/rtl/sigdot_rsp_queue.sv @@
// Two-entry result queue in front of the response channel.
module sigdot_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  sigdot_pkg::sigdot_result_type push,
   input  logic                          pop,
   output logic                          head_valid,
   output logic                          full,
   output sigdot_pkg::sigdot_rsp_type    head
);

   logic [1:0]                 count_ff;
   logic [1:0]                 count_in;
   sigdot_pkg::sigdot_rsp_type slot0_ff;
   sigdot_pkg::sigdot_rsp_type slot1_ff;
   sigdot_pkg::sigdot_rsp_type slot0_in;
   sigdot_pkg::sigdot_rsp_type slot1_in;
   sigdot_pkg::sigdot_rsp_type data;

   assign data = '{activation: push.activation, count_error: push.count_error};

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      unique case ({push.valid, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               slot0_in = data;
            end else begin
               slot1_in = data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            slot0_in = slot1_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign head_valid = count_ff != 2'd0;
   assign full       = count_ff == 2'd2;
   assign head       = slot0_ff;

endmodule

@@ hw/rtl/sigmoid_neuron_dot_product_unit.sv @@
// Sigmoid neuron top level: configuration registers, intake control and result channel.
// Weight writes and non-final samples are taken one item per clock while req_ready is high.
// A final sample passes the MAC and activation pipeline registers before rsp_valid; intake pauses
// until its result enters the two-entry result queue.
// The activation pipeline holds bias add, split scale multiply, clamp, lookup and blend.
// Synchronous reset clears control state, accumulator and sample count and loads register defaults.
module sigmoid_neuron_dot_product_unit #(
   parameter int MAX_INPUTS = sigdot_pkg::MAX_INPUTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic [sigdot_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [sigdot_pkg::VALUE_W-1:0] req_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sigdot_pkg::ACT_W-1:0]          rsp_activation,
   output logic                                  rsp_count_error,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sigdot_pkg::CSR_W-1:0]          csr_index,
   input  logic [sigdot_pkg::VALUE_W-1:0]        csr_data
);

   logic [sigdot_pkg::COUNT_W-1:0]          input_count_ff;
   logic signed [sigdot_pkg::VALUE_W-1:0]   bias_weight_ff;
   logic signed [sigdot_pkg::VALUE_W-1:0]   bias_input_ff;
   logic [sigdot_pkg::VALUE_W-1:0]          inv_resp_ff;
   logic signed [2*sigdot_pkg::VALUE_W-1:0] bias_prod_ff;

   logic                          inflight_ff;
   logic                          req_accept;
   logic                          q_full;
   sigdot_pkg::sigdot_sum_type    mac_sum;
   sigdot_pkg::sigdot_result_type act_result;
   sigdot_pkg::sigdot_rsp_type    q_head;

   assign csr_ready  = 1'b1;
   assign req_ready  = !inflight_ff && !q_full;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_count_ff <= sigdot_pkg::INPUT_COUNT_RST;
         bias_weight_ff <= sigdot_pkg::BIAS_WEIGHT_RST;
         bias_input_ff  <= sigdot_pkg::BIAS_INPUT_RST;
         inv_resp_ff    <= sigdot_pkg::INV_RESP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sigdot_pkg::CSR_INPUT_COUNT: input_count_ff <= csr_data[sigdot_pkg::COUNT_W-1:0];
            sigdot_pkg::CSR_BIAS_WEIGHT: bias_weight_ff <= $signed(csr_data);
            sigdot_pkg::CSR_BIAS_INPUT:  bias_input_ff  <= $signed(csr_data);
            sigdot_pkg::CSR_INV_RESP:    inv_resp_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      bias_prod_ff <= (2*sigdot_pkg::VALUE_W)'(bias_weight_ff)
                      * (2*sigdot_pkg::VALUE_W)'(bias_input_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 1'b0;
      end else if (req_accept && req_mode && req_last) begin
         inflight_ff <= 1'b1;
      end else if (act_result.valid) begin
         inflight_ff <= 1'b0;
      end
   end

   sigdot_mac #(
      .MAX_INPUTS (MAX_INPUTS)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .item_take   (req_accept),
      .item_mode   (req_mode),
      .item_index  (req_index),
      .item_value  (req_value),
      .item_last   (req_last),
      .input_count (input_count_ff),
      .sum_out     (mac_sum)
   );

   sigdot_act u_act (
      .clock        (clock),
      .reset        (reset),
      .sum_in       (mac_sum),
      .bias_product (bias_prod_ff),
      .inv_resp     (inv_resp_ff),
      .result       (act_result)
   );

   sigdot_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (act_result),
      .pop        (rsp_valid && rsp_ready),
      .head_valid (rsp_valid),
      .full       (q_full),
      .head       (q_head)
   );

   assign rsp_activation  = q_head.activation;
   assign rsp_count_error = q_head.count_error;

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      act_result.valid |-> !q_full)
      else $error("result pushed into full queue");

   a_hold_after_last : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode && req_last) |=> !req_ready)
      else $error("intake open after final sample");

   a_result_only_inflight : assert property (@(posedge clock) disable iff (reset)
      act_result.valid |-> inflight_ff)
      else $error("result without a pending vector");

   a_sum_only_inflight : assert property (@(posedge clock) disable iff (reset)
      mac_sum.valid |-> inflight_ff)
      else $error("vector sum without a pending vector");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the sigmoid neuron unit, with a built-in predictor of each activation.
module tb_top;

   localparam bit MODE_WEIGHT = 1'b0;
   localparam bit MODE_SAMPLE = 1'b1;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic                                  req_mode;
   logic [sigdot_pkg::INDEX_W-1:0]        req_index;
   logic signed [sigdot_pkg::VALUE_W-1:0] req_value;
   logic                                  req_last;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic [sigdot_pkg::ACT_W-1:0]          rsp_activation;
   logic                                  rsp_count_error;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [sigdot_pkg::CSR_W-1:0]          csr_index;
   logic [sigdot_pkg::VALUE_W-1:0]        csr_data;

   sigmoid_neuron_dot_product_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_index       (req_index),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_activation  (rsp_activation),
      .rsp_count_error (rsp_count_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // predictor state and configuration
   logic signed [sigdot_pkg::VALUE_W-1:0] weight_mem [sigdot_pkg::MAX_INPUTS_DEF] =
      '{default: '0};
   longint                                acc_sum = 0;
   int                                    sample_cnt = 0;
   int                                    in_count = 1;
   logic signed [sigdot_pkg::VALUE_W-1:0] bias_wt = 16'sd0;
   logic signed [sigdot_pkg::VALUE_W-1:0] bias_in = 16'sd4096;
   longint                                inv_resp = 256;
   longint                                sig_lut [sigdot_pkg::SIG_ENTRIES+1];
   sigdot_pkg::sigdot_rsp_type            activation_q [$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold = 0;
   int items_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint clamp40(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (sigdot_pkg::ACC_W - 1)) - 1;
      lo = -(longint'(1) <<< (sigdot_pkg::ACC_W - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // e^-|x| by a truncated series squared eight times, then the logistic point
   function automatic longint sigmoid_point(int k);
      longint      x;
      longint      ax;
      logic [63:0] one;
      logic [63:0] y;
      logic [63:0] y2;
      logic [63:0] y3;
      logic [63:0] y4;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] q;
      one = 64'd1 << 31;
      x = longint'(k) * 1048576 / sigdot_pkg::SIG_ENTRIES - 524288;
      ax = (x < 0) ? -x : x;
      y = 64'(ax) << 7;
      y2 = (y * y) >> 31;
      y3 = (y2 * y) >> 31;
      y4 = (y3 * y) >> 31;
      e = one - y + (y2 >> 1) - y3 / 64'd6 + y4 / 64'd24;
      for (int n = 0; n < 8; n++) begin
         e = (e * e + (one >> 1)) >> 31;
      end
      den = one + e;
      num = (x >= 0) ? (64'd1 << 47) : (e << 16);
      q = (num + den / 64'd2) / den;
      if (q > 64'd65535) q = 64'd65535;
      return longint'(q);
   endfunction

   function automatic logic [sigdot_pkg::ACT_W-1:0] sigmoid_of(longint z);
      longint lim;
      longint p;
      longint i;
      longint f;
      longint r;
      lim = longint'(8) <<< 32;
      if (z < -lim) z = -lim;
      if (z > lim) z = lim;
      p = (z + lim) * sigdot_pkg::SIG_ENTRIES;
      i = p >>> 36;
      if (i >= sigdot_pkg::SIG_ENTRIES)
         return sig_lut[sigdot_pkg::SIG_ENTRIES][sigdot_pkg::ACT_W-1:0];
      f = (p & ((longint'(1) <<< 36) - 1)) >>> 20;
      r = (sig_lut[i] * (65536 - f) + sig_lut[i+1] * f + 32768) >>> 16;
      if (r > 65535) r = 65535;
      return r[sigdot_pkg::ACT_W-1:0];
   endfunction

   function automatic void accumulate_item(bit mode, logic [sigdot_pkg::INDEX_W-1:0] idx,
                                           logic signed [sigdot_pkg::VALUE_W-1:0] val,
                                           bit is_last);
      longint                     s;
      sigdot_pkg::sigdot_rsp_type r;
      if (mode == MODE_WEIGHT) begin
         weight_mem[idx] = val;
         return;
      end
      acc_sum = clamp40(acc_sum + longint'(val) * longint'(weight_mem[idx]));
      if (sample_cnt < 127) sample_cnt++;
      if (!is_last) return;
      s = clamp40(acc_sum + longint'(bias_wt) * longint'(bias_in));
      r.activation = sigmoid_of(s * inv_resp);
      r.count_error = (sample_cnt != in_count);
      activation_q = {activation_q, r};
      acc_sum = 0;
      sample_cnt = 0;
   endfunction

   function automatic logic signed [sigdot_pkg::VALUE_W-1:0] rand_q312();
      int pick;
      int v;
      pick = $urandom_range(9);
      v = int'($urandom_range(8191)) - 4096;
      case (pick)
         0: v = 32767;
         1: v = -32768;
         2: v = 0;
         3, 4: v = int'($urandom());
         default: ;
      endcase
      return v[sigdot_pkg::VALUE_W-1:0];
   endfunction

   task automatic flag_error(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic send_item(bit mode, logic [sigdot_pkg::INDEX_W-1:0] idx,
                            logic signed [sigdot_pkg::VALUE_W-1:0] val, bit is_last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_index <= idx;
      req_value <= val;
      req_last <= is_last;
      do @(posedge clock); while (!req_ready);
      accumulate_item(mode, idx, val, is_last);
      items_sent++;
   endtask

   // drop valid, wait for every activation, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (activation_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [sigdot_pkg::CSR_W-1:0] sel,
                          logic [sigdot_pkg::VALUE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         sigdot_pkg::CSR_INPUT_COUNT: in_count = int'(data[sigdot_pkg::COUNT_W-1:0]);
         sigdot_pkg::CSR_BIAS_WEIGHT: bias_wt = data;
         sigdot_pkg::CSR_BIAS_INPUT:  bias_in = data;
         sigdot_pkg::CSR_INV_RESP:    inv_resp = longint'(data);
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic load_config(int ic, logic [sigdot_pkg::VALUE_W-1:0] bw,
                              logic [sigdot_pkg::VALUE_W-1:0] bi,
                              logic [sigdot_pkg::VALUE_W-1:0] inv);
      settle();
      csr_put(sigdot_pkg::CSR_INPUT_COUNT, sigdot_pkg::VALUE_W'(ic));
      csr_put(sigdot_pkg::CSR_BIAS_WEIGHT, bw);
      csr_put(sigdot_pkg::CSR_BIAS_INPUT, bi);
      csr_put(sigdot_pkg::CSR_INV_RESP, inv);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      send_item(MODE_WEIGHT, 0, 16'sh7fff, 1'b0);
      send_item(MODE_WEIGHT, 63, 16'sh8000, 1'b1);
      send_item(MODE_WEIGHT, 21, 16'sd4096, 1'b0);
      send_item(MODE_SAMPLE, 21, 16'sd0, 1'b1);
      send_item(MODE_SAMPLE, 0, 16'sh7fff, 1'b1);
      send_item(MODE_SAMPLE, 63, 16'sh8000, 1'b1);
      send_item(MODE_SAMPLE, 63, 16'sh7fff, 1'b1);
      send_item(MODE_SAMPLE, 21, -16'sd4096, 1'b0);
      send_item(MODE_SAMPLE, 21, 16'sd8192, 1'b1);
      load_config(0, 16'h8000, 16'h8000, 16'd1);
      send_item(MODE_SAMPLE, 21, 16'sd0, 1'b1);
      send_item(MODE_SAMPLE, 0, 16'sh8000, 1'b1);
      load_config(64, 16'h7fff, 16'h8000, 16'hffff);
      send_item(MODE_SAMPLE, 21, 16'sd1, 1'b1);
      send_item(MODE_SAMPLE, 0, 16'sh7fff, 1'b1);
      // sum lands exactly on the top of the table
      load_config(1, 16'd1, 16'd4096, 16'd256);
      send_item(MODE_SAMPLE, 21, 16'sh7fff, 1'b1);
      send_item(MODE_SAMPLE, 21, 16'sh7ffe, 1'b1);
      send_item(MODE_SAMPLE, 21, 16'sh8000, 1'b1);
   endtask

   // overflow the accumulator, then pull back into range;
   // count also saturates, so 127 must match
   task automatic test_acc_saturation();
      load_config(127, 16'd0, 16'd4096, 16'd256);
      repeat (516) send_item(MODE_SAMPLE, 63, 16'sh8000, 1'b0);
      for (int j = 0; j < 512; j++) send_item(MODE_SAMPLE, 63, 16'sh7fff, j == 511);
   endtask

   task automatic test_back_pressure();
      load_config(1, 16'd0, 16'd4096, 16'd256);
      rx_hold = 300;
      repeat (16) send_item(MODE_SAMPLE, 21, rand_q312(), 1'b1);
      settle();
   endtask

   task automatic run_vectors(int budget);
      int stop_at;
      int base;
      int len;
      stop_at = items_sent + budget;
      base = (in_count == 0) ? 1 : in_count;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 8) begin
            send_item(MODE_WEIGHT, sigdot_pkg::INDEX_W'($urandom_range(63)), rand_q312(),
                      1'($urandom_range(1)));
         end else begin
            len = ($urandom_range(9) < 8) ? base : $urandom_range(1, base + 2);
            for (int j = 0; j < len; j++) begin
               if ($urandom_range(49) == 0) begin
                  send_item(MODE_WEIGHT, sigdot_pkg::INDEX_W'($urandom_range(63)),
                            rand_q312(), 1'b0);
               end
               send_item(MODE_SAMPLE, sigdot_pkg::INDEX_W'($urandom_range(63)), rand_q312(),
                         j == len - 1);
            end
         end
      end
   endtask

   task automatic test_random();
      int ic;
      for (int k = 0; k < sigdot_pkg::MAX_INPUTS_DEF; k++) begin
         send_item(MODE_WEIGHT, sigdot_pkg::INDEX_W'(k), rand_q312(), 1'($urandom_range(1)));
      end
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         tx_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 85 : 0;
         rx_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 25 : 0;
         ic = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 12);
         case (ph)
            0: load_config(64, 16'h7fff, 16'h8000, 16'hffff);
            1: load_config(1, 16'h8000, 16'h8000, 16'd1);
            default: load_config(ic, sigdot_pkg::VALUE_W'($urandom()),
                                 sigdot_pkg::VALUE_W'($urandom()),
                                 ($urandom_range(3) == 0)
                                    ? sigdot_pkg::VALUE_W'($urandom_range(1, 65535))
                                    : sigdot_pkg::VALUE_W'($urandom_range(1, 512)));
         endcase
         run_vectors(95);
      end
   endtask

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold > 0) begin
            rsp_ready <= 1'b0;
            rx_hold--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      sigdot_pkg::sigdot_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (activation_q.size() == 0) begin
            flag_error($sformatf("unexpected activation %0d", rsp_activation));
         end else begin
            want = activation_q.pop_front();
            if (rsp_activation !== want.activation) begin
               flag_error($sformatf("activation %0d, expected %0d", rsp_activation,
                                    want.activation));
            end
            if (rsp_count_error !== want.count_error) begin
               flag_error($sformatf("count_error %0b, expected %0b", rsp_count_error,
                                    want.count_error));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Stalled for %0d cycles with %0d activations outstanding",
                     quiet_cycles, activation_q.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      for (int k = 0; k <= sigdot_pkg::SIG_ENTRIES; k++) sig_lut[k] = sigmoid_point(k);
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_WEIGHT;
      req_index <= '0;
      req_value <= '0;
      req_last <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= sigdot_pkg::CSR_INPUT_COUNT;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_acc_saturation();
      test_back_pressure();
      test_random();
      settle();
      $display("Run covered %0d items, %0d activations and %0d register writes", items_sent,
               results_seen, csr_writes);
      $display("Phases: directed edges, accumulator saturation, back-pressure, random stalls");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
